>>> sv/nlmd_pkg.sv
// Shared constants, codes and lookup tables for the non-local-means denoiser.
package nlmd_pkg;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CFG_BITS    = 7;
    localparam int COORD_BITS  = 6;
    localparam int PIX_BITS    = 8;
    localparam int WTAB_Q      = 24;
    localparam int RECIP_SHIFT = 18;
    localparam int SUM_BITS    = 13;
    localparam int CNT_BITS    = 5;
    localparam int RECIP_BITS  = 19;
    localparam int COUNT_BITS  = 14;

    localparam logic [2:0] WIN_LAST   = 3'd4;
    localparam logic [8:0] WIN_RADIUS = 9'd2;

    // exp(-d*d/25) in Q0.24, d = 0 saturated, zero from d = 21 on
    function automatic logic [WTAB_Q-1:0] weight_q24(input logic [PIX_BITS-1:0] d);
        logic [WTAB_Q-1:0] w;
        case (d)
            8'd0:    w = 24'd16777215;
            8'd1:    w = 24'd16119371;
            8'd2:    w = 24'd14296600;
            8'd3:    w = 24'd11705066;
            8'd4:    w = 24'd8846498;
            8'd5:    w = 24'd6171992;
            8'd6:    w = 24'd3974988;
            8'd7:    w = 24'd2363212;
            8'd8:    w = 24'd1296958;
            8'd9:    w = 24'd657061;
            8'd10:   w = 24'd307285;
            8'd11:   w = 24'd132658;
            8'd12:   w = 24'd52866;
            8'd13:   w = 24'd19448;
            8'd14:   w = 24'd6604;
            8'd15:   w = 24'd2070;
            8'd16:   w = 24'd599;
            8'd17:   w = 24'd160;
            8'd18:   w = 24'd39;
            8'd19:   w = 24'd8;
            8'd20:   w = 24'd1;
            default: w = 24'd0;
        endcase
        return w;
    endfunction

    // ceil(2^18 / cnt); exact floor division for sums below 6400
    function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
        logic [RECIP_BITS-1:0] m;
        case (cnt)
            5'd1:    m = 19'd262144;
            5'd2:    m = 19'd131072;
            5'd3:    m = 19'd87382;
            5'd4:    m = 19'd65536;
            5'd5:    m = 19'd52429;
            5'd6:    m = 19'd43691;
            5'd7:    m = 19'd37450;
            5'd8:    m = 19'd32768;
            5'd9:    m = 19'd29128;
            5'd10:   m = 19'd26215;
            5'd11:   m = 19'd23832;
            5'd12:   m = 19'd21846;
            5'd13:   m = 19'd20165;
            5'd14:   m = 19'd18725;
            5'd15:   m = 19'd17477;
            5'd16:   m = 19'd16384;
            5'd17:   m = 19'd15421;
            5'd18:   m = 19'd14564;
            5'd19:   m = 19'd13798;
            5'd20:   m = 19'd13108;
            5'd21:   m = 19'd12484;
            5'd22:   m = 19'd11916;
            5'd23:   m = 19'd11398;
            5'd24:   m = 19'd10923;
            5'd25:   m = 19'd10486;
            default: m = 19'd0;
        endcase
        return m;
    endfunction

endpackage

>>> sv/nlmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nlmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/non_local_means_denoiser_unit.sv
// Top level of the grayscale non-local-means denoiser.
//
//  channel   | handshake                  | word
//  ----------+----------------------------+------------------------------
//  item      | item_valid / item_stall    | command, col, row, pixel
//  result    | result_valid / result_stall| denoised
//  config    | cfg_write                  | cfg_index, cfg_data
//
// Compute reads one pixel per cycle from the pixel and mean RAMs; if the
// means are stale, it first rebuilds them, one window read per cycle from
// the pixel RAM.
// Reset marks the means stale; RAM contents are undefined until written.
// item_stall is high while a compute runs; a finished word waits in the output
// register and only blocks the block when a second result is ready.
module non_local_means_denoiser_unit
    import nlmd_pkg::*;
#(
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_HEIGHT  = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  command,
    input  logic [COORD_BITS-1:0] col,
    input  logic [COORD_BITS-1:0] row,
    input  logic [PIX_BITS-1:0]   pixel,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [PIX_BITS-1:0]   denoised,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data
);

    localparam int CA    = $clog2(MAX_WIDTH);
    localparam int RA    = $clog2(MAX_HEIGHT);
    localparam int AW    = CA + RA;
    localparam int DEPTH = 2 ** AW;
    localparam int NW    = WEIGHT_BITS + PIX_BITS + COUNT_BITS;
    localparam int DW    = WEIGHT_BITS + COUNT_BITS;
    localparam int PW    = WEIGHT_BITS + PIX_BITS;
    localparam int MPW   = SUM_BITS + RECIP_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MEAN_DRAIN,
        ST_CENTER,
        ST_CENTER_LATCH,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    function automatic logic [AW-1:0] mk_addr(input logic [CFG_BITS-1:0] r,
                                              input logic [CFG_BITS-1:0] c);
        return {RA'(r), CA'(c)};
    endfunction

    state_t                state_reg;
    logic [CFG_BITS-1:0]   width_reg;
    logic [CFG_BITS-1:0]   height_reg;
    logic                  stale_reg;
    logic [CFG_BITS-1:0]   col_reg;
    logic [CFG_BITS-1:0]   row_reg;
    logic [CFG_BITS-1:0]   sr_reg;
    logic [CFG_BITS-1:0]   sc_reg;
    logic [2:0]            wi_reg;
    logic [2:0]            wj_reg;
    logic [2:0]            dcnt_reg;
    logic                  result_valid_reg;
    logic                  m1_valid_reg;
    logic                  m2_valid_reg;
    logic                  m3_valid_reg;
    logic                  s1_valid_reg;
    logic                  s2_valid_reg;

    logic                  m1_inside_reg;
    logic                  m1_first_reg;
    logic                  m1_last_reg;
    logic [AW-1:0]         m1_addr_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [AW-1:0]         m2_addr_reg;
    logic [MPW-1:0]        mprod_reg;
    logic [AW-1:0]         m3_addr_reg;
    logic [PIX_BITS-1:0]   center_reg;
    logic [PW-1:0]         sprod_reg;
    logic [WEIGHT_BITS-1:0] swt_reg;
    logic [NW-1:0]         num_reg;
    logic [DW-1:0]         den_reg;
    logic [NW-1:0]         rem_reg;
    logic [PIX_BITS-1:0]   q_reg;
    logic [PIX_BITS-1:0]   denoised_reg;

    logic [CFG_BITS-1:0]   w_eff;
    logic [CFG_BITS-1:0]   h_eff;
    logic                  in_accept;
    logic                  store_inside;
    logic [8:0]            rr9;
    logic [8:0]            cc9;
    logic                  win_inside;
    logic                  win_first;
    logic                  win_last;
    logic                  col_end;
    logic                  row_end;
    logic [AW-1:0]         win_addr;
    logic [AW-1:0]         scan_addr;
    logic [AW-1:0]         center_addr;
    logic                  pix_we;
    logic [AW-1:0]         pix_waddr;
    logic                  pix_re;
    logic [AW-1:0]         pix_raddr;
    logic [PIX_BITS-1:0]   pix_rdata;
    logic                  mean_re;
    logic [AW-1:0]         mean_raddr;
    logic [PIX_BITS-1:0]   mean_rdata;
    logic [PIX_BITS-1:0]   diff;
    logic [WEIGHT_BITS-1:0] wt;
    logic [SUM_BITS-1:0]   sum_next;
    logic [CNT_BITS-1:0]   cnt_next;
    logic [NW-1:0]         trial;
    logic                  out_load;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = CFG_BITS'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = CFG_BITS'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = CFG_BITS'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = CFG_BITS'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign in_accept    = item_valid && !item_stall;
    assign store_inside = ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);

    // window position, negative offsets wrap into bit 8
    assign rr9        = {2'b00, sr_reg} + {6'b0, wi_reg} - WIN_RADIUS;
    assign cc9        = {2'b00, sc_reg} + {6'b0, wj_reg} - WIN_RADIUS;
    assign win_inside = !rr9[8] && (rr9[7:0] < {1'b0, h_eff})
                     && !cc9[8] && (cc9[7:0] < {1'b0, w_eff});
    assign win_first  = (wi_reg == '0) && (wj_reg == '0);
    assign win_last   = (wi_reg == WIN_LAST) && (wj_reg == WIN_LAST);
    assign col_end    = (sc_reg == w_eff - CFG_BITS'(1));
    assign row_end    = (sr_reg == h_eff - CFG_BITS'(1));

    assign win_addr    = mk_addr(rr9[CFG_BITS-1:0], cc9[CFG_BITS-1:0]);
    assign scan_addr   = mk_addr(sr_reg, sc_reg);
    assign center_addr = mk_addr(row_reg, col_reg);

    assign pix_we     = in_accept && (command == CMD_STORE) && store_inside;
    assign pix_waddr  = mk_addr({1'b0, row}, {1'b0, col});
    assign pix_re     = (state_reg == ST_MEAN) || (state_reg == ST_SCAN);
    assign pix_raddr  = (state_reg == ST_MEAN) ? win_addr : scan_addr;
    assign mean_re    = (state_reg == ST_CENTER) || (state_reg == ST_SCAN);
    assign mean_raddr = (state_reg == ST_SCAN) ? scan_addr : center_addr;

    nlmd_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (DEPTH)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pixel),
        .re    (pix_re),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    nlmd_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (DEPTH)
    ) u_mean_ram (
        .clk   (clk),
        .we    (m3_valid_reg),
        .waddr (m3_addr_reg),
        .wdata (mprod_reg[RECIP_SHIFT +: PIX_BITS]),
        .re    (mean_re),
        .raddr (mean_raddr),
        .rdata (mean_rdata)
    );

    assign diff = (mean_rdata > center_reg) ? (mean_rdata - center_reg)
                                            : (center_reg - mean_rdata);
    assign wt   = WEIGHT_BITS'(weight_q24(diff) >> (WTAB_Q - WEIGHT_BITS));

    assign sum_next = (m1_first_reg ? '0 : sum_reg)
                    + (m1_inside_reg ? {{(SUM_BITS-PIX_BITS){1'b0}}, pix_rdata} : '0);
    assign cnt_next = (m1_first_reg ? '0 : cnt_reg)
                    + (m1_inside_reg ? CNT_BITS'(1) : '0);

    assign trial    = NW'(den_reg) << dcnt_reg;
    assign out_load = (state_reg == ST_FINISH) && (!result_valid_reg || !result_stall);

    // control: sequencer, pipeline valids and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            width_reg        <= CFG_BITS'(64);
            height_reg       <= CFG_BITS'(64);
            stale_reg        <= 1'b1;
            result_valid_reg <= 1'b0;
            m1_valid_reg     <= 1'b0;
            m2_valid_reg     <= 1'b0;
            m3_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            sr_reg           <= '0;
            sc_reg           <= '0;
            wi_reg           <= '0;
            wj_reg           <= '0;
            dcnt_reg         <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            m1_valid_reg <= (state_reg == ST_MEAN);
            m2_valid_reg <= m1_valid_reg && m1_last_reg;
            m3_valid_reg <= m2_valid_reg;
            s1_valid_reg <= (state_reg == ST_SCAN);
            s2_valid_reg <= s1_valid_reg;

            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                stale_reg <= 1'b1;
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (command == CMD_STORE)
                        begin
                            if (store_inside)
                                stale_reg <= 1'b1;
                        end
                        else
                        begin
                            col_reg   <= ({1'b0, col} < w_eff) ? {1'b0, col}
                                                               : w_eff - CFG_BITS'(1);
                            row_reg   <= ({1'b0, row} < h_eff) ? {1'b0, row}
                                                               : h_eff - CFG_BITS'(1);
                            sr_reg    <= '0;
                            sc_reg    <= '0;
                            wi_reg    <= '0;
                            wj_reg    <= '0;
                            state_reg <= stale_reg ? ST_MEAN : ST_CENTER;
                        end
                    end
                end
                ST_MEAN:
                begin
                    if (wj_reg != WIN_LAST)
                        wj_reg <= wj_reg + 3'd1;
                    else
                    begin
                        wj_reg <= '0;
                        if (wi_reg != WIN_LAST)
                            wi_reg <= wi_reg + 3'd1;
                        else
                        begin
                            wi_reg <= '0;
                            if (!col_end)
                                sc_reg <= sc_reg + CFG_BITS'(1);
                            else
                            begin
                                sc_reg <= '0;
                                if (!row_end)
                                    sr_reg <= sr_reg + CFG_BITS'(1);
                                else
                                begin
                                    sr_reg    <= '0;
                                    state_reg <= ST_MEAN_DRAIN;
                                end
                            end
                        end
                    end
                end
                ST_MEAN_DRAIN:
                begin
                    if (!m1_valid_reg && !m2_valid_reg && !m3_valid_reg)
                    begin
                        stale_reg <= 1'b0;
                        state_reg <= ST_CENTER;
                    end
                end
                ST_CENTER:
                begin
                    state_reg <= ST_CENTER_LATCH;
                end
                ST_CENTER_LATCH:
                begin
                    sr_reg    <= '0;
                    sc_reg    <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (!col_end)
                        sc_reg <= sc_reg + CFG_BITS'(1);
                    else
                    begin
                        sc_reg <= '0;
                        if (!row_end)
                            sr_reg <= sr_reg + CFG_BITS'(1);
                        else
                            state_reg <= ST_SCAN_DRAIN;
                    end
                end
                ST_SCAN_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg)
                    begin
                        dcnt_reg  <= 3'd7;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    dcnt_reg <= dcnt_reg - 3'd1;
                    if (dcnt_reg == '0)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        m1_inside_reg <= win_inside;
        m1_first_reg  <= win_first;
        m1_last_reg   <= win_last;
        m1_addr_reg   <= mk_addr(sr_reg, sc_reg);

        if (m1_valid_reg)
        begin
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            m2_addr_reg <= m1_addr_reg;
        end
        if (m2_valid_reg)
        begin
            mprod_reg   <= MPW'(sum_reg) * MPW'(recip(cnt_reg));
            m3_addr_reg <= m2_addr_reg;
        end

        if (state_reg == ST_CENTER_LATCH)
        begin
            center_reg <= mean_rdata;
            num_reg    <= '0;
            den_reg    <= '0;
        end
        else if (s2_valid_reg)
        begin
            num_reg <= num_reg + NW'(sprod_reg);
            den_reg <= den_reg + DW'(swt_reg);
        end
        if (s1_valid_reg)
        begin
            sprod_reg <= PW'(wt) * PW'(pix_rdata);
            swt_reg   <= wt;
        end

        // restoring division, quotient known to fit in eight bits
        if (state_reg == ST_SCAN_DRAIN)
        begin
            rem_reg <= num_reg;
            q_reg   <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg          <= rem_reg - trial;
                q_reg[dcnt_reg]  <= 1'b1;
            end
        end

        if (out_load)
            denoised_reg <= (den_reg == '0) ? '0 : q_reg;
    end

    assign result_valid = result_valid_reg;
    assign denoised     = denoised_reg;

endmodule

>>> sv/nlmd_chk.sv
// Port-level checker for the denoiser, bound to the top level.
module nlmd_chk
    import nlmd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input logic                  command,
    input logic [COORD_BITS-1:0] col,
    input logic [COORD_BITS-1:0] row,
    input logic [PIX_BITS-1:0]   pixel,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic [PIX_BITS-1:0]   denoised,
    input logic                  cfg_write,
    input logic                  cfg_index,
    input logic [CFG_BITS-1:0]   cfg_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(denoised))
        else $error("result word changed under stall");

    // a store never produces a result
    a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command == CMD_STORE && !result_valid
        |=> !result_valid)
        else $error("store produced a result");

    // a compute occupies the block
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command == CMD_COMPUTE |=> item_stall)
        else $error("input not stalled after compute");

    // results appear only at the end of a compute
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result without a running compute");

endmodule

bind non_local_means_denoiser_unit nlmd_chk u_nlmd_chk (.*);
